>>> rtl/alrb_pkg.sv
`timescale 1ns / 1ps

package alrb_pkg;

  localparam int NUM_KINDS = 5;
  localparam int MAX_ROWS  = 65536;

  // Row index stops at min(MAX_ROWS - 1, 65535)
  localparam logic [15:0] ROW_LIMIT =
    ((MAX_ROWS - 1) > 65535) ? 16'hFFFF : 16'(MAX_ROWS - 1);

  localparam int APB_AW = 5;

  typedef enum logic [2:0] {
    KIND_ALT = 3'd0,
    KIND_PRS = 3'd1,
    KIND_TMP = 3'd2,
    KIND_VLT = 3'd3,
    KIND_STS = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_ALT_RATE = 3'd0,
    REG_PRS_RATE = 3'd1,
    REG_TMP_RATE = 3'd2,
    REG_VLT_RATE = 3'd3,
    REG_STS_RATE = 3'd4
  } reg_idx_t;

  // Record label bytes
  localparam logic [7:0] LABEL_ALT = 8'h41;  // 'A'
  localparam logic [7:0] LABEL_PRS = 8'h50;  // 'P'
  localparam logic [7:0] LABEL_TMP = 8'h54;  // 'T'
  localparam logic [7:0] LABEL_VLT = 8'h56;  // 'V'
  localparam logic [7:0] LABEL_STS = 8'h53;  // 'S'

  // Payload lengths in bytes
  localparam logic [2:0] LEN_ALT = 3'd4;
  localparam logic [2:0] LEN_PRS = 3'd4;
  localparam logic [2:0] LEN_TMP = 3'd2;
  localparam logic [2:0] LEN_VLT = 3'd2;
  localparam logic [2:0] LEN_STS = 3'd1;

  localparam logic [15:0] RST_ALT_RATE = 16'd5;
  localparam logic [15:0] RST_PRS_RATE = 16'd0;
  localparam logic [15:0] RST_TMP_RATE = 16'd100;
  localparam logic [15:0] RST_VLT_RATE = 16'd100;
  localparam logic [15:0] RST_STS_RATE = 16'd0;

  typedef struct packed {
    logic [15:0]        row_index;
    logic [31:0]        row_time;
    logic signed [31:0] altitude_cm;
    logic [31:0]        pressure_raw;
    logic signed [15:0] temperature_centi;
    logic [15:0]        voltage_mv;
    logic [7:0]         flight_state;
    logic [30:0]        max_height_cm;
  } row_t;

endpackage

>>> rtl/altimeter_log_row_builder_core.sv
`timescale 1ns / 1ps

// Altimeter log row builder.
// Input channel (in_valid/in_ready): one recording byte per item plus a flag
// marking the last byte of the recording. Records are a label byte ('A', 'P',
// 'T', 'V', 'S') and a little-endian payload; unknown labels are skipped.
// Output channel (out_valid/out_ready): one sample-and-hold row per completed
// record of the pace type (lowest nonzero rate, altitude if all are zero).
// Config: APB-style, rate registers at byte addresses 0x00..0x10, pready tied
// high; writes are expected only while the block is idle.
// Throughput: one byte per cycle while in_ready is high. Each byte is parsed
// on the edge that accepts it; a row goes to out_r (skid_r if the head stalls).
// Stall: a two-entry output queue (result register + skid register) keeps
// in_ready high while one row waits; in_ready drops only when both are full.
// Reset (rst_n low, synchronous): rates return to defaults, parser and held
// row clear, output queue empties. The last byte of a recording is parsed
// (it may finish a record and emit a row) and then all parse state clears.

module altimeter_log_row_builder_core
  import alrb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // byte stream
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last_of_recording,
  // rows
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_row_index,
  output logic [31:0]              out_row_time,
  output logic signed [31:0]       out_altitude_cm,
  output logic [31:0]              out_pressure_raw,
  output logic signed [15:0]       out_temperature_centi,
  output logic [15:0]              out_voltage_mv,
  output logic [7:0]               out_flight_state,
  output logic [30:0]              out_max_height_cm,
  // config
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // ---------------------------------------------------------------- config
  logic [15:0] rate_r [NUM_KINDS];
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r[KIND_ALT] <= RST_ALT_RATE;
      rate_r[KIND_PRS] <= RST_PRS_RATE;
      rate_r[KIND_TMP] <= RST_TMP_RATE;
      rate_r[KIND_VLT] <= RST_VLT_RATE;
      rate_r[KIND_STS] <= RST_STS_RATE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALT_RATE: rate_r[KIND_ALT] <= pwdata[15:0];
        REG_PRS_RATE: rate_r[KIND_PRS] <= pwdata[15:0];
        REG_TMP_RATE: rate_r[KIND_TMP] <= pwdata[15:0];
        REG_VLT_RATE: rate_r[KIND_VLT] <= pwdata[15:0];
        REG_STS_RATE: rate_r[KIND_STS] <= pwdata[15:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALT_RATE: prdata = {16'b0, rate_r[KIND_ALT]};
      REG_PRS_RATE: prdata = {16'b0, rate_r[KIND_PRS]};
      REG_TMP_RATE: prdata = {16'b0, rate_r[KIND_TMP]};
      REG_VLT_RATE: prdata = {16'b0, rate_r[KIND_VLT]};
      REG_STS_RATE: prdata = {16'b0, rate_r[KIND_STS]};
      default:      prdata = 32'b0;
    endcase
  end

  // ------------------------------------------------------------ pace pick
  // lowest nonzero rate, first on a tie; step stays 0 if none is set
  kind_t       pace_kind;
  logic [15:0] pace_rate;
  logic        pace_found;

  always_comb begin
    pace_kind  = KIND_ALT;
    pace_rate  = 16'b0;
    pace_found = 1'b0;
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (rate_r[k] != 16'b0 && (!pace_found || rate_r[k] < pace_rate)) begin
        pace_kind  = kind_t'(3'(k));
        pace_rate  = rate_r[k];
        pace_found = 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ row state
  logic [2:0]  phase_r,   phase_nxt;    // payload bytes still due
  kind_t       kind_r,    kind_nxt;
  logic [31:0] shift_r,   shift_nxt;
  logic [31:0] alt_r,     alt_nxt;
  logic [31:0] prs_r,     prs_nxt;
  logic [15:0] tmp_r,     tmp_nxt;
  logic [15:0] vlt_r,     vlt_nxt;
  logic [7:0]  sts_r,     sts_nxt;
  logic [31:0] time_r,    time_nxt;
  logic [15:0] rows_r,    rows_nxt;
  logic [31:0] ground_r,  ground_nxt;
  logic [30:0] peak_r,    peak_nxt;

  logic               in_fire;
  logic [31:0]        shift_new;
  logic [31:0]        ground_sel;   // ground level seen by a finishing altitude
  logic signed [32:0] agl;
  logic [32:0]        time_sum;
  logic               res_valid;
  row_t               res;

  assign in_fire    = in_valid & in_ready;
  assign shift_new  = {in_data_byte, shift_r[31:8]};
  assign ground_sel = (rows_r == 16'd0) ? shift_new : ground_r;
  assign agl        = $signed({shift_new[31], shift_new}) - $signed({ground_sel[31], ground_sel});
  assign time_sum   = {1'b0, time_r} + {17'b0, pace_rate};

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    shift_nxt  = shift_r;
    alt_nxt    = alt_r;
    prs_nxt    = prs_r;
    tmp_nxt    = tmp_r;
    vlt_nxt    = vlt_r;
    sts_nxt    = sts_r;
    time_nxt   = time_r;
    rows_nxt   = rows_r;
    ground_nxt = ground_r;
    peak_nxt   = peak_r;
    res_valid  = 1'b0;
    res        = '0;

    if (in_fire) begin
      if (phase_r == 3'd0) begin
        // label byte
        unique case (in_data_byte)
          LABEL_ALT: begin kind_nxt = KIND_ALT; phase_nxt = LEN_ALT; shift_nxt = '0; end
          LABEL_PRS: begin kind_nxt = KIND_PRS; phase_nxt = LEN_PRS; shift_nxt = '0; end
          LABEL_TMP: begin kind_nxt = KIND_TMP; phase_nxt = LEN_TMP; shift_nxt = '0; end
          LABEL_VLT: begin kind_nxt = KIND_VLT; phase_nxt = LEN_VLT; shift_nxt = '0; end
          LABEL_STS: begin kind_nxt = KIND_STS; phase_nxt = LEN_STS; shift_nxt = '0; end
          default: ;  // unknown label, skip
        endcase
      end else begin
        shift_nxt = shift_new;
        phase_nxt = phase_r - 3'd1;
        if (phase_r == 3'd1) begin
          unique case (kind_r)
            KIND_ALT: begin
              alt_nxt = shift_new;
              if (rows_r == 16'd0) ground_nxt = shift_new;
            end
            KIND_PRS: prs_nxt = shift_new;
            KIND_TMP: tmp_nxt = shift_new[31:16];
            KIND_VLT: vlt_nxt = shift_new[31:16];
            KIND_STS: sts_nxt = shift_new[31:24];
            default:  sts_nxt = shift_new[31:24];
          endcase
          // height above ground, clamped to 31 bits
          if (kind_r == KIND_ALT && !agl[32] && agl[31:0] > {1'b0, peak_r})
            peak_nxt = agl[31] ? 31'h7FFF_FFFF : agl[30:0];

          if (kind_r == pace_kind) begin
            res_valid             = 1'b1;
            res.row_index         = rows_r;
            res.row_time          = time_r;
            res.altitude_cm       = alt_nxt;
            res.pressure_raw      = prs_nxt;
            res.temperature_centi = tmp_nxt;
            res.voltage_mv        = vlt_nxt;
            res.flight_state      = sts_nxt;
            res.max_height_cm     = peak_nxt;
            if (rows_r < ROW_LIMIT) rows_nxt = rows_r + 16'd1;
            time_nxt = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
          end
        end
      end

      if (in_last_of_recording) begin
        phase_nxt  = 3'd0;
        kind_nxt   = KIND_ALT;
        shift_nxt  = '0;
        alt_nxt    = '0;
        prs_nxt    = '0;
        tmp_nxt    = '0;
        vlt_nxt    = '0;
        sts_nxt    = '0;
        time_nxt   = '0;
        rows_nxt   = '0;
        ground_nxt = '0;
        peak_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 3'd0;
      kind_r   <= KIND_ALT;
      shift_r  <= '0;
      alt_r    <= '0;
      prs_r    <= '0;
      tmp_r    <= '0;
      vlt_r    <= '0;
      sts_r    <= '0;
      time_r   <= '0;
      rows_r   <= '0;
      ground_r <= '0;
      peak_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      shift_r  <= shift_nxt;
      alt_r    <= alt_nxt;
      prs_r    <= prs_nxt;
      tmp_r    <= tmp_nxt;
      vlt_r    <= vlt_nxt;
      sts_r    <= sts_nxt;
      time_r   <= time_nxt;
      rows_r   <= rows_nxt;
      ground_r <= ground_nxt;
      peak_r   <= peak_nxt;
    end
  end

  // --------------------------------------------------------- output queue
  // out_r is the head, skid_r catches a row made while the head is stalled
  logic out_valid_r,  out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  row_t out_r,  out_nxt;
  row_t skid_r, skid_nxt;
  logic out_fire;

  assign out_fire = out_valid_r & out_ready;
  assign in_ready = ~skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_ready) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_row_index         = out_r.row_index;
  assign out_row_time          = out_r.row_time;
  assign out_altitude_cm       = out_r.altitude_cm;
  assign out_pressure_raw      = out_r.pressure_raw;
  assign out_temperature_centi = out_r.temperature_centi;
  assign out_voltage_mv        = out_r.voltage_mv;
  assign out_flight_state      = out_r.flight_state;
  assign out_max_height_cm     = out_r.max_height_cm;

  // ----------------------------------------------------------- assertions
  // skid entry only ever sits behind a valid head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without head entry");

  // a label byte never produces a row
  a_no_row_on_label: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == 3'd0) |-> !res_valid)
    else $error("row produced by a label byte");

  // last byte of a recording leaves the parser and row counters clear
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_of_recording) |=>
      (phase_r == 3'd0 && rows_r == 16'd0 && time_r == 32'd0 && peak_r == 31'd0))
    else $error("state not cleared after last byte");

  // payload counter never exceeds the longest record
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= LEN_ALT)
    else $error("payload byte count out of range");

endmodule
